// ===== rtl/core/aqi_pkg.sv =====
// Shared package for the air quality index calculator.
// Holds the pollutant breakpoint tables, the transaction payload structs and the categories.
// Depends on nothing; every module of the block imports it.
package aqi_pkg;

	localparam int CONC_BITS   = 16;
	localparam int IDX_BITS    = 13;
	localparam int ROWS        = 6;
	localparam int ROW_BITS    = $clog2(ROWS);
	localparam int SEG_IDX_BITS = 10;

	// Concentration offset within one segment never exceeds the widest span (249.0).
	localparam int DIFF_BITS   = 12;
	// Reciprocal slope in fixed point; the shift keeps the truncated quotient exact
	// for every offset within a segment.
	localparam int RECIP_SHIFT = 23;
	localparam int RECIP_BITS  = 29;
	// Interpolated part of a sub-index is at most 100.0 points.
	localparam int QUOT_BITS   = 10;

	localparam logic [IDX_BITS-1:0] IDX_ABOVE          = IDX_BITS'(5000);
	localparam logic [IDX_BITS-1:0] LIMIT_GOOD         = IDX_BITS'(500);
	localparam logic [IDX_BITS-1:0] LIMIT_SATISFACTORY = IDX_BITS'(1000);
	localparam logic [IDX_BITS-1:0] LIMIT_MODERATE     = IDX_BITS'(2000);
	localparam logic [IDX_BITS-1:0] LIMIT_POOR         = IDX_BITS'(3000);
	localparam logic [IDX_BITS-1:0] LIMIT_VERY_POOR    = IDX_BITS'(4000);

	typedef enum logic [2:0] {
		CAT_GOOD,
		CAT_SATISFACTORY,
		CAT_MODERATE,
		CAT_POOR,
		CAT_VERY_POOR,
		CAT_SEVERE
	} aqi_cat_t;

	typedef enum logic [1:0] {
		POL_PM25,
		POL_CO,
		POL_NO2
	} aqi_pol_t;

	// One breakpoint row: concentration bounds in tenths, index bounds in whole points.
	typedef struct packed {
		logic [CONC_BITS-1:0]    clo;
		logic [CONC_BITS-1:0]    chi;
		logic [SEG_IDX_BITS-1:0] ilo;
		logic [SEG_IDX_BITS-1:0] ihi;
	} aqi_seg_t;

	typedef aqi_seg_t aqi_tab_t [ROWS];

	localparam aqi_tab_t PM25_TAB = '{
		'{16'd0,    16'd300,  10'd0,   10'd50},
		'{16'd310,  16'd600,  10'd51,  10'd100},
		'{16'd610,  16'd900,  10'd101, 10'd200},
		'{16'd910,  16'd1200, 10'd201, 10'd300},
		'{16'd1210, 16'd2500, 10'd301, 10'd400},
		'{16'd2510, 16'd5000, 10'd401, 10'd500}
	};

	localparam aqi_tab_t CO_TAB = '{
		'{16'd0,   16'd10,  10'd0,   10'd50},
		'{16'd11,  16'd20,  10'd51,  10'd100},
		'{16'd21,  16'd100, 10'd101, 10'd200},
		'{16'd101, 16'd170, 10'd201, 10'd300},
		'{16'd171, 16'd340, 10'd301, 10'd400},
		'{16'd341, 16'd500, 10'd401, 10'd500}
	};

	localparam aqi_tab_t NO2_TAB = '{
		'{16'd0,    16'd400,  10'd0,   10'd50},
		'{16'd410,  16'd800,  10'd51,  10'd100},
		'{16'd810,  16'd1800, 10'd101, 10'd200},
		'{16'd1810, 16'd2800, 10'd201, 10'd300},
		'{16'd2810, 16'd4000, 10'd301, 10'd400},
		'{16'd4010, 16'd5000, 10'd401, 10'd500}
	};

	function automatic aqi_seg_t seg_row(aqi_pol_t pol, int row);
		aqi_seg_t seg;
		case (pol)
			POL_PM25: seg = PM25_TAB[row[ROW_BITS-1:0]];
			POL_CO:   seg = CO_TAB[row[ROW_BITS-1:0]];
			POL_NO2:  seg = NO2_TAB[row[ROW_BITS-1:0]];
			default:  seg = '0;
		endcase
		return seg;
	endfunction

	typedef struct packed {
		logic [CONC_BITS-1:0] pm25_tenths;
		logic [CONC_BITS-1:0] co_tenths;
		logic [CONC_BITS-1:0] no2_tenths;
	} aqi_sample_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] index_tenths;
		aqi_cat_t            category;
		logic [IDX_BITS-1:0] pm25_index_tenths;
		logic [IDX_BITS-1:0] co_index_tenths;
		logic [IDX_BITS-1:0] no2_index_tenths;
	} aqi_result_t;

endpackage

// ===== rtl/core/aqi_subidx.sv =====
// Sub-index of one pollutant: segment search and linear interpolation.
// Depends on aqi_pkg for the breakpoint tables and the fixed-point constants.
module aqi_subidx #(
	parameter aqi_pkg::aqi_pol_t POL = aqi_pkg::POL_PM25
) (
	input  logic [aqi_pkg::CONC_BITS-1:0] conc,
	output logic [aqi_pkg::IDX_BITS-1:0]  sub_index
);
	import aqi_pkg::*;

	localparam int PROD_BITS = DIFF_BITS + RECIP_BITS;

	logic [ROWS-1:0]       at_or_below;
	logic [ROWS-1:0]       at_or_above;
	logic [DIFF_BITS-1:0]  diff_row  [ROWS];
	logic [RECIP_BITS-1:0] recip_row [ROWS];
	logic [IDX_BITS-1:0]   base_row  [ROWS];
	logic [IDX_BITS-1:0]   gap_row   [ROWS];

	logic [ROW_BITS-1:0]   row;
	logic                  hit;
	logic [PROD_BITS-1:0]  product;
	logic [QUOT_BITS-1:0]  quotient;

	for (genvar i = 0; i < ROWS; i++) begin : g_row
		localparam aqi_seg_t SEG = seg_row(POL, i);
		localparam int PREV = (i > 0) ? i - 1 : 0;
		localparam aqi_seg_t SEG_PREV = seg_row(POL, PREV);
		localparam longint unsigned SLOPE = (longint'(SEG.ihi) - longint'(SEG.ilo)) * 10;
		localparam longint unsigned SPAN = longint'(SEG.chi) - longint'(SEG.clo);
		// Rounded-up reciprocal, so truncating the product gives the exact floor.
		localparam longint unsigned RECIP = ((SLOPE << RECIP_SHIFT) + SPAN - 1) / SPAN;
		localparam longint unsigned BASE = longint'(SEG.ilo) * 10;
		localparam longint unsigned GAP = (i > 0) ? longint'(SEG_PREV.ihi) * 10 : 0;

		assign at_or_below[i] = (conc <= SEG.chi);
		assign at_or_above[i] = (conc >= SEG.clo);
		assign diff_row[i]    = DIFF_BITS'(conc - SEG.clo);
		assign recip_row[i]   = RECIP_BITS'(RECIP);
		assign base_row[i]    = IDX_BITS'(BASE);
		assign gap_row[i]     = IDX_BITS'(GAP);
	end

	// The first row whose upper bound is not exceeded owns the concentration.
	always_comb begin
		row = '0;
		hit = 1'b0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (at_or_below[i]) begin
				row = ROW_BITS'(i);
				hit = 1'b1;
			end
		end
	end

	assign product  = PROD_BITS'(diff_row[row]) * PROD_BITS'(recip_row[row]);
	assign quotient = product[RECIP_SHIFT +: QUOT_BITS];

	// A concentration between two rows takes the upper index of the row below.
	always_comb begin
		if (!hit) begin
			sub_index = IDX_ABOVE;
		end else if (at_or_above[row]) begin
			sub_index = base_row[row] + IDX_BITS'(quotient);
		end else begin
			sub_index = gap_row[row];
		end
	end

endmodule

// ===== rtl/core/aqi_rank.sv =====
// Overall index and category from the three pollutant sub-indices.
// Depends on aqi_pkg for the result struct and the category limits.
module aqi_rank (
	input  logic [aqi_pkg::IDX_BITS-1:0] pm25_index,
	input  logic [aqi_pkg::IDX_BITS-1:0] co_index,
	input  logic [aqi_pkg::IDX_BITS-1:0] no2_index,
	output aqi_pkg::aqi_result_t         result
);
	import aqi_pkg::*;

	logic [IDX_BITS-1:0] pm_co_max;
	logic [IDX_BITS-1:0] overall;
	aqi_cat_t            category;

	assign pm_co_max = (co_index > pm25_index) ? co_index : pm25_index;
	assign overall   = (no2_index > pm_co_max) ? no2_index : pm_co_max;

	always_comb begin
		if (overall <= LIMIT_GOOD) begin
			category = CAT_GOOD;
		end else if (overall <= LIMIT_SATISFACTORY) begin
			category = CAT_SATISFACTORY;
		end else if (overall <= LIMIT_MODERATE) begin
			category = CAT_MODERATE;
		end else if (overall <= LIMIT_POOR) begin
			category = CAT_POOR;
		end else if (overall <= LIMIT_VERY_POOR) begin
			category = CAT_VERY_POOR;
		end else begin
			category = CAT_SEVERE;
		end
	end

	assign result.index_tenths      = overall;
	assign result.category          = category;
	assign result.pm25_index_tenths = pm25_index;
	assign result.co_index_tenths   = co_index;
	assign result.no2_index_tenths  = no2_index;

endmodule

// ===== rtl/core/air_quality_index_calc_unit.sv =====
// Top level of the air quality index calculator.
// Instantiates aqi_subidx (one per pollutant) and aqi_rank; uses aqi_pkg for payload types.
//
// How to use this block:
// The sample channel (sample_valid, sample_stall, sample) carries one transaction of three
// averaged concentrations in tenths: PM2.5, CO and NO2. The result channel (result_valid,
// result_stall, result) returns exactly one transaction per sample with the three
// sub-indices, the overall index (their maximum) in tenths, and its category.
// A transaction moves at a rising clock edge where valid is high and stall is low.
// The sample is captured in an input register, the breakpoint search, one constant-slope
// multiply per pollutant and the max/category logic run in one pass, and the result register
// holds the answer. Throughput is one transaction per cycle while the receiver does not stall;
// the single pass between the two registers sets that figure, as no unit is shared
// between samples.
// When the receiver stalls, the result register holds its transaction unchanged. The input
// register still takes one more sample, so sample_stall only rises once both registers
// are full, and it drops in the cycle the receiver takes the result.
// Reset (arst_n low) empties both registers at once; the block keeps no other state and is
// ready for a sample as soon as reset is released.
module air_quality_index_calc_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  aqi_pkg::aqi_sample_t sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output aqi_pkg::aqi_result_t result
);
	import aqi_pkg::*;

	logic        vld_s1;
	aqi_sample_t sample_s1;
	logic        vld_s2;
	aqi_result_t result_s2;

	logic        load_s1;
	logic        load_s2;

	logic [IDX_BITS-1:0] pm25_index;
	logic [IDX_BITS-1:0] co_index;
	logic [IDX_BITS-1:0] no2_index;
	aqi_result_t         result_next;

	// The output stage can take a new transaction when it is empty or being drained;
	// the input stage moves whenever it is empty or the output stage takes from it.
	assign load_s2      = !vld_s2 || !result_stall;
	assign load_s1      = !vld_s1 || load_s2;
	assign sample_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				vld_s1 <= sample_valid;
			end
			if (load_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && sample_valid) begin
			sample_s1 <= sample;
		end
		if (load_s2 && vld_s1) begin
			result_s2 <= result_next;
		end
	end

	aqi_subidx #(
		.POL(POL_PM25)
	) u_pm25 (
		.conc      (sample_s1.pm25_tenths),
		.sub_index (pm25_index)
	);

	aqi_subidx #(
		.POL(POL_CO)
	) u_co (
		.conc      (sample_s1.co_tenths),
		.sub_index (co_index)
	);

	aqi_subidx #(
		.POL(POL_NO2)
	) u_no2 (
		.conc      (sample_s1.no2_tenths),
		.sub_index (no2_index)
	);

	aqi_rank u_rank (
		.pm25_index (pm25_index),
		.co_index   (co_index),
		.no2_index  (no2_index),
		.result     (result_next)
	);

	assign result_valid = vld_s2;
	assign result       = result_s2;

	// A sample waiting in the input register reaches the output once the receiver is free.
	a_s1_advances: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !result_stall |=> result_valid)
		else $error("input stage transaction did not advance to the output");

	// The overall index is one of the sub-indices and no smaller than any of them.
	a_index_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.index_tenths >= result.pm25_index_tenths)
			&& (result.index_tenths >= result.co_index_tenths)
			&& (result.index_tenths >= result.no2_index_tenths)
			&& ((result.index_tenths == result.pm25_index_tenths)
				|| (result.index_tenths == result.co_index_tenths)
				|| (result.index_tenths == result.no2_index_tenths)))
		else $error("overall index is not the maximum sub-index");

	// The category agrees with the index at both ends of the scale.
	a_category_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.index_tenths <= LIMIT_GOOD) == (result.category == CAT_GOOD))
			&& ((result.index_tenths > LIMIT_VERY_POOR) == (result.category == CAT_SEVERE)))
		else $error("category does not match the overall index");

	// No sub-index can exceed the top of the scale.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.index_tenths <= IDX_ABOVE))
		else $error("overall index above 500.0");

endmodule
